@@ rtl/lba_pkg.sv @@
package lba_pkg;

  localparam int unsigned BLK_W = 10;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned REF_W = 16;
  localparam int unsigned KEY_W = 256;

  typedef enum logic [3:0] {
    CMD_INIT   = 4'd0,
    CMD_ALLOC  = 4'd1,
    CMD_FREE   = 4'd2,
    CMD_REG    = 4'd3,
    CMD_ASPEC  = 4'd4,
    CMD_TOUCH  = 4'd5,
    CMD_SETK   = 4'd6,
    CMD_CLRK   = 4'd7,
    CMD_FIND   = 4'd8,
    CMD_EVICT  = 4'd9
  } cmd_e;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_REJ  = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISP,
    ST_EXEC,
    ST_A_RD,
    ST_A_WR,
    ST_B_RD,
    ST_B_WR,
    ST_T_RD,
    ST_T_WR,
    ST_SC_RD,
    ST_SC_CMP,
    ST_WB,
    ST_EV_RD,
    ST_EV_OUT,
    ST_RESP
  } state_e;

  // per-block record in the metadata memory
  typedef struct packed {
    logic [REF_W-1:0] refcnt;
    logic             queued;
    logic             kv;
    logic             it;
    logic [BLK_W-1:0] prev;
    logic [BLK_W-1:0] next;
  } meta_t;

  // one result beat
  typedef struct packed {
    logic [BLK_W-1:0] blk;
    logic [1:0]       status;
    logic [CNT_W-1:0] free;
    logic             last;
  } beat_t;

endpackage

@@ rtl/lba_out_reg.sv @@
module lba_out_reg
  import lba_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  beat_t beat_i,
  input  logic  ready_i,
  output logic  valid_o,
  output beat_t beat_o,
  output logic  free_o
);

  logic  valid_q;
  beat_t beat_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      beat_q <= beat_i;
    end
  end

endmodule

@@ rtl/lru_block_allocator_hash_index.sv @@
// Block pool manager: reference counts, an LRU free queue and a 256-bit key index.
// Input channel s_axis: one command beat (cmd, target id, four key words, max_count).
// Output channel m_axis: result beats {result_block, status, free_count}, tlast on
// the final beat of a command. evict_list gives up to min(max_count, MAX_LIST) beats.
// Config: cfg_we_i writes the init pool size, used by the next init command.
// One command at a time; per-block state sits in two single-port-style memories
// (metadata and keys) with a registered read:
//   simple commands (alloc without key, free, register, touch, alloc specific)
//   update the neighbor links by read-modify-write; rejected ids, misses and
//   unknown commands go straight to the response;
//   find, set_key, clear_key and alloc of a keyed block scan the key memory,
//   reading and then comparing each entry in turn;
//   evict_list reads each entry before its beat; init sweeps all NUM_BLOCKS records.
// Reset: a sweep over all NUM_BLOCKS records rebuilds the full queue; s_axis_tready_o
// stays low meanwhile, configuration writes are taken.
// A result sits in an output register; a stalled receiver holds the block only
// when the next result is ready to leave.
module lru_block_allocator_hash_index
  import lba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = 1024,
  parameter int unsigned MAX_LIST   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // cmd[3:0], target_id[14:4], key_word0..3[270:15], max_count[277:271], zero
  input  logic [279:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // result_block[9:0], status[11:10], free_count[22:12], zero
  output logic [23:0]  m_axis_tdata_o,
  output logic         m_axis_tlast_o,
  input  logic         cfg_we_i,
  input  logic [10:0]  cfg_wdata_i
);

  localparam int unsigned AW = $clog2(NUM_BLOCKS);

  state_e state_q, state_d;

  // memories
  meta_t            meta_mem [NUM_BLOCKS];
  logic [KEY_W-1:0] key_mem  [NUM_BLOCKS];
  meta_t            meta_rd_q;
  logic [KEY_W-1:0] key_rd_q;

  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             me_we;
  logic [AW-1:0]    me_wa;
  meta_t            me_wd;
  logic             ke_we;

  // control registers
  logic [AW-1:0]    j_q;
  logic             init_cmd_q;
  logic [CNT_W-1:0] init_q;
  logic [BLK_W-1:0] head_q, tail_q;
  logic [CNT_W-1:0] cnt_q;

  // command payload
  logic [3:0]       cmd_q;
  logic [10:0]      id_q;
  logic [KEY_W-1:0] key_q;
  logic [6:0]       max_q;

  // working registers
  logic [BLK_W-1:0] b_q, blk_q, lk_prev_q, lk_next_q, ta_q, cur_q;
  logic [1:0]       st_q;
  meta_t            mb_q;
  logic [KEY_W-1:0] kold_q;
  logic             sc_old_q, sc_new_q;
  logic             pend_t_q;
  logic [6:0]       left_q;

  logic             s_acc;
  logic             out_load, out_free;
  beat_t            out_beat, out_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------- dispatch decode ----------------
  logic             in_range, usable, disp_exec;
  logic [1:0]       disp_st;
  logic [BLK_W-1:0] disp_b;
  logic [6:0]       mc, cap;

  always_comb begin
    in_range = id_q < 11'(NUM_BLOCKS);
    usable   = in_range && (id_q != 11'd0);
    disp_b   = in_range ? id_q[BLK_W-1:0] : '0;
    mc       = (max_q > 7'(MAX_LIST)) ? 7'(MAX_LIST) : max_q;
    cap      = ({4'd0, mc} > cnt_q) ? cnt_q[6:0] : mc;
    disp_exec = 1'b0;
    disp_st   = STAT_OK;
    case (cmd_q)
      CMD_ALLOC: begin
        disp_b = head_q;
        if (cnt_q == '0) disp_st = STAT_MISS;
        else disp_exec = 1'b1;
      end
      CMD_FREE, CMD_REG, CMD_ASPEC: begin
        if (!usable) disp_st = STAT_REJ;
        else disp_exec = 1'b1;
      end
      CMD_TOUCH, CMD_SETK, CMD_CLRK: begin
        if (!in_range) disp_st = STAT_REJ;
        else disp_exec = 1'b1;
      end
      CMD_EVICT: begin
        if (cap == 7'd0) disp_st = STAT_MISS;
      end
      default: ;
    endcase
  end

  // ---------------- execute: update the target record and queue ----------------
  meta_t            ex_m;
  logic [BLK_W-1:0] ex_h, ex_t, ex_ta, ex_blk;
  logic [CNT_W-1:0] ex_c;
  logic             ex_ab, ex_rt, ex_old, ex_new, do_rm, do_push;

  always_comb begin
    ex_m    = meta_rd_q;
    ex_h    = head_q;
    ex_t    = tail_q;
    ex_c    = cnt_q;
    ex_ta   = tail_q;
    ex_ab   = 1'b0;
    ex_rt   = 1'b0;
    ex_old  = 1'b0;
    ex_new  = 1'b0;
    do_rm   = 1'b0;
    do_push = 1'b0;
    ex_blk  = '0;
    case (cmd_q)
      CMD_ALLOC: begin
        do_rm     = 1'b1;
        ex_m.refcnt = 16'd1;
        ex_old    = meta_rd_q.kv;
        ex_m.kv   = 1'b0;
        ex_m.it   = 1'b0;
        ex_blk    = b_q;
      end
      CMD_FREE: begin
        if (meta_rd_q.refcnt <= 16'd1) begin
          ex_m.refcnt = '0;
          do_push     = 1'b1;
        end else begin
          ex_m.refcnt = meta_rd_q.refcnt - 16'd1;
        end
      end
      CMD_REG: begin
        do_push = (meta_rd_q.refcnt == '0);
      end
      CMD_ASPEC: begin
        if (meta_rd_q.refcnt != '0) begin
          if (meta_rd_q.refcnt != 16'hFFFF) ex_m.refcnt = meta_rd_q.refcnt + 16'd1;
        end else begin
          do_rm       = 1'b1;
          ex_m.refcnt = 16'd1;
        end
        ex_blk = b_q;
      end
      CMD_TOUCH: begin
        if (b_q != '0 && meta_rd_q.refcnt == '0) begin
          do_rm   = 1'b1;
          do_push = 1'b1;
        end
      end
      CMD_SETK: begin
        ex_old  = meta_rd_q.kv;
        ex_new  = 1'b1;
        ex_m.kv = 1'b1;
        ex_m.it = 1'b1;
      end
      CMD_CLRK: begin
        ex_old  = meta_rd_q.kv;
        ex_m.kv = 1'b0;
        ex_m.it = 1'b0;
      end
      default: ;
    endcase
    if (do_rm && ex_m.queued) begin
      if (ex_c <= 11'd1) begin
        // sole entry: pointers stay as they are
      end else if (b_q == ex_h) begin
        ex_h = meta_rd_q.next;
      end else if (b_q == ex_t) begin
        ex_t = meta_rd_q.prev;
      end else begin
        ex_ab = 1'b1;
      end
      ex_m.queued = 1'b0;
      ex_c        = ex_c - 11'd1;
    end
    if (do_push && !ex_m.queued) begin
      if (ex_c == '0) begin
        ex_h = b_q;
      end else begin
        ex_rt     = 1'b1;
        ex_ta     = ex_t;
        ex_m.prev = ex_t;
      end
      ex_t        = b_q;
      ex_m.queued = 1'b1;
      ex_c        = ex_c + 11'd1;
    end
  end

  // ---------------- scan compare ----------------
  logic scan_match, scan_last, is_find;
  assign is_find    = (cmd_q == CMD_FIND);
  assign scan_match = meta_rd_q.it && meta_rd_q.kv &&
                      ((sc_old_q && key_rd_q == kold_q) || (sc_new_q && key_rd_q == key_q));
  assign scan_last  = (j_q == AW'(NUM_BLOCKS - 1));

  // ---------------- init sweep word ----------------
  logic [CNT_W-1:0] n_src, n_eff, ie;
  meta_t            sw_word;
  always_comb begin
    // the sweep after reset always builds the full pool
    n_src          = init_cmd_q ? init_q : 11'd1024;
    n_eff          = (n_src > 11'(NUM_BLOCKS)) ? 11'(NUM_BLOCKS) : n_src;
    ie             = 11'(j_q);
    sw_word        = '0;
    sw_word.queued = (ie >= 11'd1) && (ie < n_eff);
    sw_word.prev   = (ie >= 11'd2 && ie < n_eff) ? BLK_W'(ie - 11'd1) : '0;
    sw_word.next   = (ie + 11'd1 < n_eff) ? BLK_W'(ie + 11'd1) : '0;
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT:   if (scan_last) state_d = init_cmd_q ? ST_RESP : ST_IDLE;
      ST_IDLE:   if (s_acc) state_d = ST_DISP;
      ST_DISP: begin
        if (cmd_q == CMD_INIT) state_d = ST_INIT;
        else if (cmd_q == CMD_FIND) state_d = ST_SC_RD;
        else if (cmd_q == CMD_EVICT && disp_st == STAT_OK) state_d = ST_EV_RD;
        else if (disp_exec) state_d = ST_EXEC;
        else state_d = ST_RESP;
      end
      ST_EXEC: begin
        if (ex_ab) state_d = ST_A_RD;
        else if (ex_rt) state_d = ST_T_RD;
        else if (ex_old || ex_new) state_d = ST_SC_RD;
        else state_d = ST_WB;
      end
      ST_A_RD:   state_d = ST_A_WR;
      ST_A_WR:   state_d = ST_B_RD;
      ST_B_RD:   state_d = ST_B_WR;
      ST_B_WR: begin
        if (pend_t_q) state_d = ST_T_RD;
        else if (sc_old_q || sc_new_q) state_d = ST_SC_RD;
        else state_d = ST_WB;
      end
      ST_T_RD:   state_d = ST_T_WR;
      ST_T_WR:   state_d = (sc_old_q || sc_new_q) ? ST_SC_RD : ST_WB;
      ST_SC_RD:  state_d = ST_SC_CMP;
      ST_SC_CMP: begin
        if (is_find && scan_match) state_d = ST_RESP;
        else if (scan_last) state_d = is_find ? ST_RESP : ST_WB;
        else state_d = ST_SC_RD;
      end
      ST_WB:     state_d = ST_RESP;
      ST_EV_RD:  state_d = ST_EV_OUT;
      ST_EV_OUT: if (out_free) state_d = (left_q == 7'd1) ? ST_IDLE : ST_EV_RD;
      ST_RESP:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------- memory and output controls ----------------
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = j_q;
    me_we    = 1'b0;
    me_wa    = j_q;
    me_wd    = meta_rd_q;
    ke_we    = 1'b0;
    out_load = 1'b0;
    out_beat = '{blk: blk_q, status: st_q, free: cnt_q, last: 1'b1};
    unique case (state_q)
      ST_INIT: begin
        me_we = 1'b1;
        me_wd = sw_word;
      end
      ST_DISP: begin
        rd_en   = disp_exec;
        rd_addr = disp_b[AW-1:0];
      end
      ST_A_RD: begin
        rd_en   = 1'b1;
        rd_addr = lk_prev_q[AW-1:0];
      end
      ST_A_WR: begin
        me_we      = 1'b1;
        me_wa      = lk_prev_q[AW-1:0];
        me_wd.next = lk_next_q;
      end
      ST_B_RD: begin
        rd_en   = 1'b1;
        rd_addr = lk_next_q[AW-1:0];
      end
      ST_B_WR: begin
        me_we      = 1'b1;
        me_wa      = lk_next_q[AW-1:0];
        me_wd.prev = lk_prev_q;
      end
      ST_T_RD: begin
        rd_en   = 1'b1;
        rd_addr = ta_q[AW-1:0];
      end
      ST_T_WR: begin
        me_we      = 1'b1;
        me_wa      = ta_q[AW-1:0];
        me_wd.next = b_q;
      end
      ST_SC_RD: begin
        rd_en = 1'b1;
      end
      ST_SC_CMP: begin
        // the target block itself is rewritten at the end of the command
        me_we    = !is_find && scan_match && (j_q != b_q[AW-1:0]);
        me_wd.it = 1'b0;
      end
      ST_WB: begin
        me_we = 1'b1;
        me_wa = b_q[AW-1:0];
        me_wd = mb_q;
        ke_we = (cmd_q == CMD_SETK);
      end
      ST_EV_RD: begin
        rd_en   = 1'b1;
        rd_addr = cur_q[AW-1:0];
      end
      ST_EV_OUT: begin
        out_load = out_free;
        out_beat = '{blk: cur_q, status: STAT_OK, free: cnt_q, last: (left_q == 7'd1)};
      end
      ST_RESP: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk_i) begin
    if (me_we) meta_mem[me_wa] <= me_wd;
    if (rd_en) meta_rd_q <= meta_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (ke_we) key_mem[b_q[AW-1:0]] <= key_q;
    if (rd_en) key_rd_q <= key_mem[rd_addr];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      j_q        <= '0;
      init_cmd_q <= 1'b0;
      init_q     <= 11'd1024;
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) init_q <= cfg_wdata_i;
      case (state_q)
        ST_INIT: begin
          if (scan_last) begin
            j_q <= '0;
            if (n_eff >= 11'd2) begin
              head_q <= BLK_W'(1);
              tail_q <= BLK_W'(n_eff - 11'd1);
              cnt_q  <= n_eff - 11'd1;
            end else begin
              head_q <= '0;
              tail_q <= '0;
              cnt_q  <= '0;
            end
          end else begin
            j_q <= j_q + AW'(1);
          end
        end
        ST_DISP: begin
          j_q        <= '0;
          init_cmd_q <= 1'b1;
        end
        ST_EXEC: begin
          head_q <= ex_h;
          tail_q <= ex_t;
          cnt_q  <= ex_c;
        end
        ST_SC_CMP: j_q <= j_q + AW'(1);
        default: ;
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          cmd_q <= s_axis_tdata_i[3:0];
          id_q  <= s_axis_tdata_i[14:4];
          key_q <= s_axis_tdata_i[270:15];
          max_q <= s_axis_tdata_i[277:271];
        end
      end
      ST_DISP: begin
        blk_q    <= '0;
        st_q     <= disp_st;
        b_q      <= disp_b;
        sc_old_q <= 1'b0;
        sc_new_q <= (cmd_q == CMD_FIND);
        left_q   <= cap;
        cur_q    <= head_q;
      end
      ST_EXEC: begin
        mb_q      <= ex_m;
        lk_prev_q <= meta_rd_q.prev;
        lk_next_q <= meta_rd_q.next;
        ta_q      <= ex_ta;
        pend_t_q  <= ex_rt;
        sc_old_q  <= ex_old;
        sc_new_q  <= ex_new;
        kold_q    <= key_rd_q;
        blk_q     <= ex_blk;
      end
      ST_SC_CMP: begin
        if (is_find && scan_match) begin
          blk_q <= BLK_W'(j_q);
          st_q  <= STAT_OK;
        end else if (is_find && scan_last) begin
          st_q <= STAT_MISS;
        end
      end
      ST_EV_OUT: begin
        if (out_free) begin
          cur_q  <= meta_rd_q.next;
          left_q <= left_q - 7'd1;
        end
      end
      default: ;
    endcase
  end

  lba_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .beat_i  (out_beat),
    .ready_i (m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .beat_o  (out_q),
    .free_o  (out_free)
  );

  assign m_axis_tdata_o = {1'b0, out_q.free, out_q.status, out_q.blk};
  assign m_axis_tlast_o = out_q.last;

endmodule
